// File: sv/hrl_pkg.sv
// Package for the hex record loader.
// Holds the character and record codes, the result type and the hex digit decoder.
// Used by every module of the block; depends on nothing.
package hrl_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  localparam logic       KIND_WRITE = 1'b0;
  localparam logic       KIND_DONE  = 1'b1;

  localparam logic [16:0] NO_ADDR       = 17'h1FFFF;
  localparam logic [16:0] MEM_LIMIT_RST = 17'h10000;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: sv/hex_record_loader.sv
// Top level of the hex record loader.
// Instantiates the record parser and the result register; depends on hrl_pkg.
//
// The block reads an Intel HEX text stream one character per transfer on the
// in_ channel (in_ch, plus in_stream_end to mark the end of input). Each data
// byte of a data record whose address lies below the memory limit gives one
// write result on the out_ channel (out_kind 0, out_address, out_data_byte).
// An EOF record or in_stream_end gives one done result (out_kind 1) carrying
// the lowest data record address, or 0 if no data record was seen; after it
// all input is consumed and ignored.
// A result appears on the out_ channel in the cycle after the character that
// caused it. One character is taken every cycle as long as the result
// register is empty or its result is taken in the same cycle; in_stall is
// high only while a result waits under out_stall.
// cfg_we and cfg_wdata write the memory limit, which resets to 65536.
// Reset clears the line state, the entry address and the result register.
module hex_record_loader import hrl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_data_byte,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  logic    load;
  logic    acc;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_stall = !load;
  assign acc      = in_valid && load;

  hrl_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .ch         (in_ch),
    .stream_end (in_stream_end),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  hrl_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .load      (load),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind      = out_res.kind;
  assign out_address   = out_res.address;
  assign out_data_byte = out_res.data_byte;

endmodule

// File: sv/hrl_parser.sv
// Record parser of the hex record loader: line state, field decode and address check.
// Steps once per accepted character and produces at most one result in the same cycle.
// Depends on hrl_pkg.
module hrl_parser import hrl_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    ch,
  input  logic          stream_end,
  input  logic          cfg_we,
  input  logic [16:0]   cfg_wdata,
  output logic          res_valid,
  output result_t       res
);

  localparam logic [1:0] PH_LINE_START = 2'd0;
  localparam logic [1:0] PH_SKIP       = 2'd1;
  localparam logic [1:0] PH_HEADER     = 2'd2;
  localparam logic [1:0] PH_DATA       = 2'd3;

  localparam logic [1:0] FLD_COUNT   = 2'd0;
  localparam logic [1:0] FLD_ADDR_HI = 2'd1;
  localparam logic [1:0] FLD_ADDR_LO = 2'd2;
  localparam logic [1:0] FLD_TYPE    = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic        nibble_pos_r, nibble_pos_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [1:0]  field_index_r, field_index_nxt;
  logic [7:0]  count_left_r, count_left_nxt;
  logic [15:0] record_addr_r, record_addr_nxt;
  logic [7:0]  data_offset_r, data_offset_nxt;
  logic [16:0] lowest_addr_r, lowest_addr_nxt;
  logic        finished_r, finished_nxt;
  logic [16:0] mem_limit_r;

  hex_t        hx;
  logic [7:0]  byte_val;
  logic [16:0] dest;

  always_comb begin
    hx       = hex_decode(ch);
    byte_val = {high_nibble_r, hx.value};
    dest     = {1'b0, record_addr_r} + {9'd0, data_offset_r};

    phase_nxt       = phase_r;
    nibble_pos_nxt  = nibble_pos_r;
    high_nibble_nxt = high_nibble_r;
    field_index_nxt = field_index_r;
    count_left_nxt  = count_left_r;
    record_addr_nxt = record_addr_r;
    data_offset_nxt = data_offset_r;
    lowest_addr_nxt = lowest_addr_r;
    finished_nxt    = finished_r;

    res_valid     = 1'b0;
    res.kind      = KIND_DONE;
    res.address   = (lowest_addr_r == NO_ADDR) ? 16'd0 : lowest_addr_r[15:0];
    res.data_byte = 8'd0;

    if (acc && !finished_r) begin
      if (stream_end) begin
        finished_nxt = 1'b1;
        phase_nxt    = PH_SKIP;
        res_valid    = 1'b1;
      end else if (ch == CH_CR) begin
        phase_nxt = phase_r;
      end else if (ch == CH_LF) begin
        phase_nxt = PH_LINE_START;
      end else if (phase_r == PH_LINE_START) begin
        if (ch == CH_COLON) begin
          phase_nxt       = PH_HEADER;
          nibble_pos_nxt  = 1'b0;
          field_index_nxt = FLD_COUNT;
          record_addr_nxt = 16'd0;
          data_offset_nxt = 8'd0;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end else if (phase_r == PH_HEADER || phase_r == PH_DATA) begin
        if (!hx.ok) begin
          phase_nxt = PH_SKIP;
        end else if (!nibble_pos_r) begin
          high_nibble_nxt = hx.value;
          nibble_pos_nxt  = 1'b1;
        end else begin
          nibble_pos_nxt = 1'b0;
          if (phase_r == PH_HEADER) begin
            case (field_index_r)
              FLD_COUNT: begin
                count_left_nxt  = byte_val;
                field_index_nxt = FLD_ADDR_HI;
              end
              FLD_ADDR_HI: begin
                record_addr_nxt = {byte_val, 8'd0};
                field_index_nxt = FLD_ADDR_LO;
              end
              FLD_ADDR_LO: begin
                record_addr_nxt = {record_addr_r[15:8], byte_val};
                field_index_nxt = FLD_TYPE;
              end
              default: begin
                field_index_nxt = FLD_COUNT;
                if (byte_val == REC_EOF) begin
                  finished_nxt = 1'b1;
                  phase_nxt    = PH_SKIP;
                  res_valid    = 1'b1;
                end else if (byte_val != REC_DATA || count_left_r == 8'd0) begin
                  phase_nxt = PH_SKIP;
                end else begin
                  if ({1'b0, record_addr_r} < lowest_addr_r) begin
                    lowest_addr_nxt = {1'b0, record_addr_r};
                  end
                  data_offset_nxt = 8'd0;
                  phase_nxt       = PH_DATA;
                end
              end
            endcase
          end else begin
            data_offset_nxt = data_offset_r + 8'd1;
            count_left_nxt  = count_left_r - 8'd1;
            if (count_left_r == 8'd1) begin
              phase_nxt = PH_SKIP;
            end
            if (dest < mem_limit_r && !dest[16]) begin
              res_valid     = 1'b1;
              res.kind      = KIND_WRITE;
              res.address   = dest[15:0];
              res.data_byte = byte_val;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LINE_START;
      nibble_pos_r  <= 1'b0;
      high_nibble_r <= 4'd0;
      field_index_r <= FLD_COUNT;
      count_left_r  <= 8'd0;
      record_addr_r <= 16'd0;
      data_offset_r <= 8'd0;
      lowest_addr_r <= NO_ADDR;
      finished_r    <= 1'b0;
      mem_limit_r   <= MEM_LIMIT_RST;
    end else begin
      phase_r       <= phase_nxt;
      nibble_pos_r  <= nibble_pos_nxt;
      high_nibble_r <= high_nibble_nxt;
      field_index_r <= field_index_nxt;
      count_left_r  <= count_left_nxt;
      record_addr_r <= record_addr_nxt;
      data_offset_r <= data_offset_nxt;
      lowest_addr_r <= lowest_addr_nxt;
      finished_r    <= finished_nxt;
      if (cfg_we) begin
        mem_limit_r <= cfg_wdata;
      end
    end
  end

  a_silent_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !res_valid)
    else $error("result produced after loading finished");

  a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_DONE) |=> finished_r)
    else $error("finished flag not set after done result");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_WRITE) |-> ({1'b0, res.address} < mem_limit_r))
    else $error("memory write beyond the memory limit");

  a_data_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (count_left_r != 8'd0))
    else $error("data phase with no bytes left");

endmodule

// File: sv/hrl_out_reg.sv
// Result register of the hex record loader.
// Holds one result for the receiver and loads a new one whenever it is empty or drained.
// Depends on hrl_pkg.
module hrl_out_reg import hrl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  input  logic    out_stall,
  output logic    load,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign load      = !(valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule
